/* src/lcgru_pkg.sv */
// Package: operation codes, generator constants and the front-to-back job record.
package lcgru_pkg;

	typedef enum logic [2:0] {
		OP_RAW      = 3'd0,
		OP_FRAC     = 3'd1,
		OP_RANGED   = 3'd2,
		OP_CHANCE   = 3'd3,
		OP_SEED_DEF = 3'd4,
		OP_SEED     = 3'd5,
		OP_SAVE     = 3'd6,
		OP_RESTORE  = 3'd7
	} op_t;

	localparam logic [31:0] LCG_MUL      = 32'h0019_660D;
	localparam logic [31:0] LCG_ADD      = 32'h3C6E_F35F;
	localparam logic [31:0] DEFAULT_SEED = 32'h00EA_A0C7;

	// Everything the back end needs about one request, apart from the
	// fraction-width fields, which travel beside it.
	typedef struct packed {
		op_t         op;
		logic [31:0] raw;
		logic [31:0] lower;
		logic [31:0] upper;
	} job_t;

	localparam int JOB_W = $bits(job_t);

endpackage

/* src/dual_stream_lcg_random_unit_core.sv */
// Top level of the dual-stream linear congruential random unit.
// Requests arrive on in_valid/in_ready, one operation per beat; every request
// gives exactly one result beat on out_valid/out_ready, in request order.
// Operations step stream A or B (state * 0x19660D + 0x3C6EF35F), form a
// masked fraction, scale it into a signed range, test it against a threshold,
// seed stream A, or save and restore both streams. Fields an operation does
// not produce come out as zero.
// The front end updates the stream state in the cycle a request is taken,
// so one request can be taken every cycle while the queue has room; the state
// update is one constant multiply-add. At the accepting edge the request is
// written into a two-entry queue; it then passes the product stage and the
// output register of the back end, and out_valid rises as it leaves them.
// If the receiver stalls, the output register holds its beat, the product
// stage and the queue fill, and in_ready falls once the queue is full.
// Reset loads stream A with the default seed, clears stream B and the saved
// copies, sets the fraction mask to all ones and empties the pipeline.
// cfg_we writes the fraction mask from cfg_wdata at the next rising edge.
module dual_stream_lcg_random_unit_core #(
	parameter int FRACTION_BITS = 23
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [FRACTION_BITS-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               req_type,
	input  logic                     stream_sel,
	input  logic signed [31:0]       lower_bound,
	input  logic signed [31:0]       upper_bound,
	input  logic [FRACTION_BITS:0]   threshold,
	input  logic [31:0]              seed_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              raw_value,
	output logic [FRACTION_BITS-1:0] fraction,
	output logic signed [31:0]       ranged_value,
	output logic                     chance_hit
);

	import lcgru_pkg::*;

	localparam int QW = JOB_W + FRACTION_BITS + FRACTION_BITS + 1;

	job_t                     f_job;
	logic [FRACTION_BITS-1:0] f_frac;
	logic                     take;
	logic [QW-1:0]            q_in;
	logic [QW-1:0]            q_out;
	logic                     q_valid;
	logic                     q_ready;
	job_t                     b_job;
	logic [FRACTION_BITS-1:0] b_frac;
	logic [FRACTION_BITS:0]   b_thr;

	assign take = in_valid && in_ready;
	assign q_in = {f_job, f_frac, threshold};
	assign {b_job, b_frac, b_thr} = q_out;

	lcgru_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.op         (op_t'(req_type)),
		.stream_sel (stream_sel),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.seed_value (seed_value),
		.job        (f_job),
		.job_frac   (f_frac)
	);

	lcgru_fifo #(
		.W(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_data (q_in),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_out)
	);

	lcgru_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job_ready   (q_ready),
		.job         (b_job),
		.job_frac    (b_frac),
		.job_thr     (b_thr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.raw_value   (raw_value),
		.fraction    (fraction),
		.ranged_value(ranged_value),
		.chance_hit  (chance_hit)
	);

endmodule

/* src/lcgru_fifo.sv */
// Two-entry queue between the request front end and the result back end.
module lcgru_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/lcgru_front.sv */
// Front end: holds both generator streams and the saved copies, steps or reloads them per request.
module lcgru_front #(
	parameter int FRACTION_BITS = 23
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [FRACTION_BITS-1:0] cfg_wdata,
	input  logic                     take,
	input  lcgru_pkg::op_t           op,
	input  logic                     stream_sel,
	input  logic [31:0]              lower_bound,
	input  logic [31:0]              upper_bound,
	input  logic [31:0]              seed_value,
	output lcgru_pkg::job_t          job,
	output logic [FRACTION_BITS-1:0] job_frac
);

	import lcgru_pkg::*;

	logic [FRACTION_BITS-1:0] mask_q;
	logic [31:0]              stream_a_q;
	logic [31:0]              stream_b_q;
	logic [31:0]              saved_a_q;
	logic [31:0]              saved_b_q;
	logic                     steps;
	logic                     use_b;
	logic [31:0]              cur;
	logic [31:0]              nxt;

	assign steps = (op == OP_FRAC) || (op == OP_RANGED) || (op == OP_CHANCE);
	assign use_b = steps && stream_sel;
	assign cur   = use_b ? stream_b_q : stream_a_q;
	assign nxt   = cur * LCG_MUL + LCG_ADD;

	always_comb begin
		job.op    = op;
		job.raw   = (steps || op == OP_RAW) ? nxt : 32'd0;
		job.lower = lower_bound;
		job.upper = upper_bound;
		job_frac  = steps ? (nxt[FRACTION_BITS-1:0] & mask_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '1;
			stream_a_q <= DEFAULT_SEED;
			stream_b_q <= 32'd0;
			saved_a_q  <= 32'd0;
			saved_b_q  <= 32'd0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (take) begin
				case (op)
					OP_RAW: begin
						stream_a_q <= nxt;
					end
					OP_FRAC, OP_RANGED, OP_CHANCE: begin
						if (use_b) begin
							stream_b_q <= nxt;
						end else begin
							stream_a_q <= nxt;
						end
					end
					OP_SEED_DEF: begin
						stream_a_q <= DEFAULT_SEED;
					end
					OP_SEED: begin
						stream_a_q <= seed_value;
					end
					OP_SAVE: begin
						saved_a_q <= stream_a_q;
						saved_b_q <= stream_b_q;
					end
					OP_RESTORE: begin
						stream_a_q <= saved_a_q;
						stream_b_q <= saved_b_q;
					end
					default: begin
						stream_a_q <= stream_a_q;
					end
				endcase
			end
		end
	end

endmodule

/* src/lcgru_back.sv */
// Back end: scales the fraction into the signed range, tests the chance and holds the result beat.
module lcgru_back #(
	parameter int FRACTION_BITS = 23
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  lcgru_pkg::job_t             job,
	input  logic [FRACTION_BITS-1:0]    job_frac,
	input  logic [FRACTION_BITS:0]      job_thr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 raw_value,
	output logic [FRACTION_BITS-1:0]    fraction,
	output logic signed [31:0]          ranged_value,
	output logic                        chance_hit
);

	import lcgru_pkg::*;

	localparam int PW = FRACTION_BITS + 34;

	// Stage 1: product of fraction and span, chance compare.
	logic                     valid_s1;
	logic                     ranged_s1;
	logic [31:0]              raw_s1;
	logic [FRACTION_BITS-1:0] frac_s1;
	logic                     hit_s1;
	logic signed [31:0]       lower_s1;
	logic signed [PW-1:0]     prod_s1;

	logic                     out_valid_q;
	logic                     s2_free;
	logic                     s1_free;
	logic                     pop;
	logic signed [FRACTION_BITS:0] frac_sg;
	logic signed [32:0]       span;
	logic signed [PW-1:0]     prod_c;
	logic signed [33:0]       floor_c;
	logic signed [34:0]       sum_c;
	logic signed [34:0]       adj_c;

	assign s2_free   = !out_valid_q || out_ready;
	assign s1_free   = !valid_s1 || s2_free;
	assign job_ready = s1_free;
	assign pop       = job_valid && s1_free;
	assign out_valid = out_valid_q;

	assign frac_sg = $signed({1'b0, job_frac});
	assign span    = $signed({job.upper[31], job.upper}) - $signed({job.lower[31], job.lower});
	assign prod_c  = PW'(frac_sg) * PW'(span);

	// Floor division by the fraction scale is an arithmetic shift; a sum that
	// lands below zero with a remainder is pulled up so the result truncates
	// toward zero.
	assign floor_c = prod_s1[PW-1:FRACTION_BITS];
	assign sum_c   = $signed({{3{lower_s1[31]}}, lower_s1}) + $signed({floor_c[33], floor_c});
	assign adj_c   = ((|prod_s1[FRACTION_BITS-1:0]) && sum_c[34]) ? sum_c + 35'sd1 : sum_c;

	always_ff @(posedge clk) begin
		if (pop) begin
			ranged_s1 <= (job.op == OP_RANGED);
			raw_s1    <= job.raw;
			frac_s1   <= job_frac;
			hit_s1    <= (job.op == OP_CHANCE) && ({1'b0, job_frac} < job_thr);
			lower_s1  <= $signed(job.lower);
			prod_s1   <= prod_c;
		end
		if (valid_s1 && s2_free) begin
			raw_value    <= raw_s1;
			fraction     <= frac_s1;
			ranged_value <= ranged_s1 ? adj_c[31:0] : 32'sd0;
			chance_hit   <= hit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= job_valid;
			end
			if (s2_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule

/* tb/tb_dual_stream_lcg_random_unit_core.sv */
// Self-checking bench for the dual-stream LCG random unit: directed table, then random phases.
`timescale 1ns / 100ps

module tb_dual_stream_lcg_random_unit_core;
	import lcgru_pkg::*;

	localparam int FB             = 23;
	localparam int CLK_HALF       = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_ITEMS    = 165;

	typedef struct packed {
		op_t                op;
		logic               sel;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
		logic [FB:0]        thr;
		logic [31:0]        seed;
	} request_t;

	typedef struct packed {
		logic [31:0]        raw;
		logic [FB-1:0]      frac;
		logic signed [31:0] ranged;
		logic               hit;
	} outcome_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		outcome_t want;
	} table_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [FB-1:0]            cfg_wdata;
	logic                     in_valid;
	logic                     in_ready;
	logic [2:0]               req_type;
	logic                     stream_sel;
	logic signed [31:0]       lower_bound;
	logic signed [31:0]       upper_bound;
	logic [FB:0]              threshold;
	logic [31:0]              seed_value;
	logic                     out_valid;
	logic                     out_ready;
	logic [31:0]              raw_value;
	logic [FB-1:0]            fraction;
	logic signed [31:0]       ranged_value;
	logic                     chance_hit;

	// Predicted generator state, kept in step with accepted requests.
	logic [31:0]   gen_a;
	logic [31:0]   gen_b;
	logic [31:0]   kept_a;
	logic [31:0]   kept_b;
	logic [FB-1:0] frac_mask;

	outcome_t   pending_outcomes[$];
	table_row_t directed_rows[$];
	outcome_t   head;
	int         fail_count  = 0;
	int         idle_cycles = 0;
	bit         calm        = 1'b0;

	dual_stream_lcg_random_unit_core #(
		.FRACTION_BITS(FB)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.stream_sel  (stream_sel),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.threshold   (threshold),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.raw_value   (raw_value),
		.fraction    (fraction),
		.ranged_value(ranged_value),
		.chance_hit  (chance_hit)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [31:0] lcg_advance(logic [31:0] s);
		return s * LCG_MUL + LCG_ADD;
	endfunction

	function automatic outcome_t predict_outcome(request_t rq);
		outcome_t    res;
		logic [31:0] nxt;
		longint      span;
		longint      prod;
		longint      acc;
		res = '0;
		case (rq.op)
			OP_RAW: begin
				gen_a   = lcg_advance(gen_a);
				res.raw = gen_a;
			end
			OP_FRAC, OP_RANGED, OP_CHANCE: begin
				if (rq.sel) begin
					gen_b = lcg_advance(gen_b);
					nxt   = gen_b;
				end else begin
					gen_a = lcg_advance(gen_a);
					nxt   = gen_a;
				end
				res.raw  = nxt;
				res.frac = nxt[FB-1:0] & frac_mask;
				if (rq.op == OP_RANGED) begin
					// Exact product, floored by the shift, then the sum is
					// nudged up where it is negative and inexact.
					span = longint'($signed(rq.upper)) - longint'($signed(rq.lower));
					prod = longint'(res.frac) * span;
					acc  = longint'($signed(rq.lower)) + (prod >>> FB);
					if (prod[FB-1:0] != 0 && acc < 0)
						acc = acc + 1;
					res.ranged = acc[31:0];
				end else if (rq.op == OP_CHANCE) begin
					res.hit = ({1'b0, res.frac} < rq.thr);
				end
			end
			OP_SEED_DEF: gen_a = DEFAULT_SEED;
			OP_SEED:     gen_a = rq.seed;
			OP_SAVE: begin
				kept_a = gen_a;
				kept_b = gen_b;
			end
			OP_RESTORE: begin
				gen_a = kept_a;
				gen_b = kept_b;
			end
		endcase
		return res;
	endfunction

	function automatic request_t mk_req(op_t op, logic sel, logic [31:0] lo, logic [31:0] up,
			logic [FB:0] thr, logic [31:0] seed);
		request_t rq;
		rq.op    = op;
		rq.sel   = sel;
		rq.lower = lo;
		rq.upper = up;
		rq.thr   = thr;
		rq.seed  = seed;
		return rq;
	endfunction

	function automatic outcome_t mk_out(logic [31:0] raw, logic [FB-1:0] frac,
			logic [31:0] rv, logic hit);
		outcome_t res;
		res.raw    = raw;
		res.frac   = frac;
		res.ranged = rv;
		res.hit    = hit;
		return res;
	endfunction

	function automatic void add_row(request_t rq, logic typed, outcome_t want);
		table_row_t row;
		row.rq    = rq;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	// Mostly short gaps, now and then a long one; none at all in a calm phase.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic request_t random_request();
		request_t    rq;
		int          pick;
		logic [31:0] swap;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			rq.op = OP_RAW;
		else if (pick < 35)
			rq.op = OP_FRAC;
		else if (pick < 60)
			rq.op = OP_RANGED;
		else if (pick < 82)
			rq.op = OP_CHANCE;
		else if (pick < 86)
			rq.op = OP_SEED_DEF;
		else if (pick < 91)
			rq.op = OP_SEED;
		else if (pick < 95)
			rq.op = OP_SAVE;
		else
			rq.op = OP_RESTORE;
		rq.sel  = 1'($urandom_range(0, 1));
		rq.seed = $urandom;
		if ($urandom_range(0, 9) == 0)
			rq.seed = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
		rq.lower = $urandom;
		case ($urandom_range(0, 4))
			0: rq.upper = $urandom;
			1: rq.upper = rq.lower + $urandom_range(0, 1000);
			2: rq.upper = rq.lower;
			3: begin
				rq.lower = 32'h8000_0000;
				rq.upper = 32'h7FFF_FFFF;
				if ($urandom_range(0, 1)) begin
					swap     = rq.lower;
					rq.lower = rq.upper;
					rq.upper = swap;
				end
			end
			default: rq.upper = rq.lower - $urandom_range(1, 1000);
		endcase
		case ($urandom_range(0, 7))
			0, 1:    rq.thr = (FB + 1)'($urandom_range(0, (1 << (FB + 1)) - 1));
			2, 3, 4: rq.thr = (FB + 1)'($urandom_range(0, 1 << FB));
			5:       rq.thr = '0;
			6:       rq.thr = (FB + 1)'(1 << FB);
			default: rq.thr = '1;
		endcase
		return rq;
	endfunction

	task automatic send_request(request_t rq, logic typed, outcome_t want);
		int       gap;
		outcome_t predicted;
		gap = idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rq.op;
		stream_sel  <= rq.sel;
		lower_bound <= rq.lower;
		upper_bound <= rq.upper;
		threshold   <= rq.thr;
		seed_value  <= rq.seed;
		do @(posedge clk); while (!in_ready);
		predicted = predict_outcome(rq);
		pending_outcomes.push_back(typed ? want : predicted);
	endtask

	initial begin
		logic [FB-1:0] mask;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		req_type    = OP_RAW;
		stream_sel  = 1'b0;
		lower_bound = '0;
		upper_bound = '0;
		threshold   = '0;
		seed_value  = '0;
		gen_a       = DEFAULT_SEED;
		gen_b       = '0;
		kept_a      = '0;
		kept_b      = '0;
		frac_mask   = '1;

		// Stream B starts at zero, so its first step gives the increment alone.
		add_row(mk_req(OP_FRAC, 1'b1, 0, 0, 0, 0), 1'b1, mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b0));
		add_row(mk_req(OP_SAVE, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_RAW, 1'b1, 0, 0, 0, 0), 1'b1, mk_out(LCG_ADD, 0, 0, 1'b0));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_RANGED, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 32'h7FFF_FFFF, 1'b0));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_CHANCE, 1'b0, 0, 0, 24'h80_0000, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b1));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_CHANCE, 1'b0, 0, 0, 24'h00_0000, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b0));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_CHANCE, 1'b0, 0, 0, 24'hFF_FFFF, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b1));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_CHANCE, 1'b0, 0, 0, 24'h6E_F35F, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b0));
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_CHANCE, 1'b0, 0, 0, 24'h6E_F360, 0), 1'b1,
			mk_out(LCG_ADD, 23'h6EF35F, 0, 1'b1));
		add_row(mk_req(OP_RESTORE, 1'b0, 0, 0, 0, 0), 1'b1, '0);
		add_row(mk_req(OP_RANGED, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 1'b0, '0);
		add_row(mk_req(OP_RANGED, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0), 1'b0, '0);
		add_row(mk_req(OP_SEED_DEF, 1'b1, 0, 0, 0, 32'hFFFF_FFFF), 1'b1, '0);
		add_row(mk_req(OP_RAW, 1'b0, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk_req(OP_FRAC, 1'b1, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk_req(OP_SEED, 1'b0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1, '0);
		add_row(mk_req(OP_RAW, 1'b0, 0, 0, 0, 0), 1'b1, mk_out(32'h3C55_8D52, 0, 0, 1'b0));
		add_row(mk_req(OP_RANGED, 1'b1, -1000, 1000, 24'hFF_FFFF, 0), 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			// The mask only changes once the pipeline has drained.
			in_valid <= 1'b0;
			while (pending_outcomes.size() != 0) @(posedge clk);
			case (phase)
				0:       mask = '1;
				1:       mask = '0;
				3:       mask = 23'h40_0001;
				5:       mask = '1;
				default: mask = FB'($urandom);
			endcase
			cfg_we    <= 1'b1;
			cfg_wdata <= mask;
			@(posedge clk);
			cfg_we    <= 1'b0;
			frac_mask = mask;
			calm      = (phase == 2);
			repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: runs of ready beats broken by stalls.
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			run   = $urandom_range(1, 12);
			stall = idle_span();
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				head = pending_outcomes.pop_front();
				if (raw_value !== head.raw) begin
					$error("raw_value: expected %h, got %h", head.raw, raw_value);
					fail_count++;
				end
				if (fraction !== head.frac) begin
					$error("fraction: expected %h, got %h", head.frac, fraction);
					fail_count++;
				end
				if (ranged_value !== head.ranged) begin
					$error("ranged_value: expected %0d, got %0d",
						$signed(head.ranged), $signed(ranged_value));
					fail_count++;
				end
				if (chance_hit !== head.hit) begin
					$error("chance_hit: expected %b, got %b", head.hit, chance_hit);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any beat on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
